FILE: rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Types, register codes and constants shared by the thermistor converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned FullScaleDefault = 4095;
  localparam int unsigned NumChannels      = 4;

  localparam int unsigned FracW    = 24;
  localparam int unsigned RatioW   = 31;
  localparam int unsigned LnMagW   = 29;
  localparam int unsigned TermW    = 35;
  localparam int unsigned SumW     = 36;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [31:0] Ln2Q32     = 32'd2977044472;
  localparam logic [34:0] Hundred28  = 35'd26843545600;
  localparam logic [17:0] Recip100   = 18'd167773;
  localparam int          TempHiCenti = 102400;
  localparam int          TempLoCenti = -12900;
  localparam logic signed [10:0] TempMax = 11'sd1023;
  localparam logic signed [10:0] TempMin = -11'sd128;

  localparam logic [13:0] BetaFirstRst  = 14'd3435;
  localparam logic [13:0] BetaOthersRst = 14'd3590;
  localparam logic [15:0] RefTempRst    = 16'd29815;
  localparam logic [14:0] OffFirstRst   = 15'd27315;
  localparam logic [14:0] OffOthersRst  = 15'd27515;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusRail  = 2'd1;
  localparam logic [1:0] StatusClamp = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBetaFirst  = 3'd0,
    CfgBetaOthers = 3'd1,
    CfgRefTemp    = 3'd2,
    CfgOffFirst   = 3'd3,
    CfgOffOthers  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  channel;
    logic [11:0] adc_code;
  } in_t;

  typedef struct packed {
    logic signed [10:0] temperature_c;
    logic [1:0]         echo_channel;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0] ch;
    logic       first;
    logic       err;
    logic       clamp;
  } flags_t;

endpackage

FILE: rtl/ntc_beta_temperature_converter.sv
// ----------------------------------------------------------------------------
// ntc_beta_temperature_converter
// Throughput: one request per cycle; the whole pipeline holds while a result
// is stalled at the output. Reset clears all valid bits and loads the
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_converter #(
  parameter int unsigned FULL_SCALE = ntc_pkg::FullScaleDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ntc_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ntc_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ntc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ntc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned FsW  = $clog2(FULL_SCALE + 1);
  localparam int unsigned CmpW = (FsW > 12) ? FsW : 12;
  localparam int unsigned RatW = FsW + ntc_pkg::FracW;
  localparam int unsigned FlW  = $bits(ntc_pkg::flags_t);

  logic [13:0] beta_first_q, beta_others_q;
  logic [15:0] ref_temp_q;
  logic [14:0] off_first_q, off_others_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_first_q  <= ntc_pkg::BetaFirstRst;
      beta_others_q <= ntc_pkg::BetaOthersRst;
      ref_temp_q    <= ntc_pkg::RefTempRst;
      off_first_q   <= ntc_pkg::OffFirstRst;
      off_others_q  <= ntc_pkg::OffOthersRst;
    end else if (cfg_valid_i) begin
      unique case (ntc_pkg::cfg_idx_e'(cfg_index_i))
        ntc_pkg::CfgBetaFirst:  beta_first_q  <= cfg_data_i[13:0];
        ntc_pkg::CfgBetaOthers: beta_others_q <= cfg_data_i[13:0];
        ntc_pkg::CfgRefTemp:    ref_temp_q    <= cfg_data_i[15:0];
        ntc_pkg::CfgOffFirst:   off_first_q   <= cfg_data_i[14:0];
        ntc_pkg::CfgOffOthers:  off_others_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // front end: rail check and divider orientation
  logic [CmpW-1:0] code_w, full_w;
  logic            rail;
  ntc_pkg::flags_t fl_in;
  logic [FsW-1:0]  num_in, den_in;

  assign code_w = CmpW'(in_data_i.adc_code);
  assign full_w = CmpW'(FULL_SCALE);
  assign rail   = (code_w == '0) || (code_w >= full_w) ||
                  ({1'b0, in_data_i.channel} >= 3'(ntc_pkg::NumChannels));

  always_comb begin
    fl_in.ch    = in_data_i.channel;
    fl_in.first = (in_data_i.channel == 2'd0);
    fl_in.err   = rail;
    fl_in.clamp = 1'b0;
    if (rail) begin
      num_in = '0;
      den_in = FsW'(1);
    end else if (fl_in.first) begin
      num_in = FsW'(full_w - code_w);
      den_in = FsW'(code_w);
    end else begin
      num_in = FsW'(code_w);
      den_in = FsW'(full_w - code_w);
    end
  end

  logic            s0_vld_q;
  logic [FsW-1:0]  s0_num_q, s0_den_q;
  ntc_pkg::flags_t s0_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_num_q   <= num_in;
      s0_den_q   <= den_in;
      s0_flags_q <= fl_in;
    end
  end

  logic            rat_vld;
  logic [RatW-1:0] rat_quo;
  logic [FlW-1:0]  rat_tag;

  ntc_div_pipe #(
    .NumW (RatW),
    .DenW (FsW),
    .TagW (FlW)
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_vld_q),
    .num_i   ({s0_num_q, {ntc_pkg::FracW{1'b0}}}),
    .den_i   (s0_den_q),
    .tag_i   (s0_flags_q),
    .valid_o (rat_vld),
    .quo_o   (rat_quo),
    .tag_o   (rat_tag)
  );

  // saturate ratio to the log range
  logic                       sat, rzero;
  logic [ntc_pkg::RatioW-1:0] r31;
  ntc_pkg::flags_t            fl_rat;

  assign sat   = |rat_quo[RatW-1:ntc_pkg::RatioW];
  assign r31   = sat ? '1 : rat_quo[ntc_pkg::RatioW-1:0];
  assign rzero = (r31 == '0);

  always_comb begin
    fl_rat       = ntc_pkg::flags_t'(rat_tag);
    fl_rat.clamp = sat || rzero;
  end

  logic                       s1_vld_q;
  logic [ntc_pkg::RatioW-1:0] s1_x_q;
  ntc_pkg::flags_t            s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= rat_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q     <= rzero ? ntc_pkg::RatioW'(1) : r31;
      s1_flags_q <= fl_rat;
    end
  end

  logic                       ln_vld, ln_neg;
  logic [ntc_pkg::LnMagW-1:0] ln_mag;
  logic [FlW-1:0]             ln_tag;

  ntc_ln_pipe #(
    .TagW (FlW)
  ) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_vld_q),
    .x_i     (s1_x_q),
    .tag_i   (s1_flags_q),
    .valid_o (ln_vld),
    .mag_o   (ln_mag),
    .neg_o   (ln_neg),
    .tag_o   (ln_tag)
  );

  // ln / beta and 1 / T0 side by side
  ntc_pkg::flags_t           fl_ln;
  logic [13:0]               beta_sel, beta_eff;
  logic [15:0]               t0_eff;
  logic [ntc_pkg::TermW-1:0] inv_dvd;

  assign fl_ln    = ntc_pkg::flags_t'(ln_tag);
  assign beta_sel = fl_ln.first ? beta_first_q : beta_others_q;
  assign beta_eff = (beta_sel == '0) ? 14'd1 : beta_sel;
  assign t0_eff   = (ref_temp_q == '0) ? 16'd1 : ref_temp_q;
  assign inv_dvd  = ntc_pkg::Hundred28 + ntc_pkg::TermW'(t0_eff[15:1]);

  logic                      term_vld, inv_vld;
  logic [ntc_pkg::TermW-1:0] term_quo, inv_quo;
  logic                      term_neg;
  logic [FlW-1:0]            inv_tag;

  ntc_div_pipe #(
    .NumW (ntc_pkg::TermW),
    .DenW (14),
    .TagW (1)
  ) u_term_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ln_vld),
    .num_i   ({2'b00, ln_mag, 4'b0000}),
    .den_i   (beta_eff),
    .tag_i   (ln_neg),
    .valid_o (term_vld),
    .quo_o   (term_quo),
    .tag_o   (term_neg)
  );

  ntc_div_pipe #(
    .NumW (ntc_pkg::TermW),
    .DenW (16),
    .TagW (FlW)
  ) u_inv_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ln_vld),
    .num_i   (inv_dvd),
    .den_i   (t0_eff),
    .tag_i   (ln_tag),
    .valid_o (inv_vld),
    .quo_o   (inv_quo),
    .tag_o   (inv_tag)
  );

  // denominator of the beta equation
  logic signed [ntc_pkg::SumW:0] term_s, sum_s;
  logic                          nonpos;

  assign term_s = term_neg ? -$signed({2'b00, term_quo}) : $signed({2'b00, term_quo});
  assign sum_s  = term_s + $signed({2'b00, inv_quo});
  assign nonpos = sum_s[ntc_pkg::SumW] || (sum_s == '0);

  logic                     s2_vld_q, s2_nonpos_q;
  logic [ntc_pkg::SumW-1:0] s2_dvd_q, s2_dvs_q;
  ntc_pkg::flags_t          s2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= term_vld && inv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dvd_q    <= ntc_pkg::SumW'(ntc_pkg::Hundred28) +
                     ntc_pkg::SumW'(sum_s[ntc_pkg::SumW-1:1]);
      s2_dvs_q    <= nonpos ? ntc_pkg::SumW'(1) : sum_s[ntc_pkg::SumW-1:0];
      s2_nonpos_q <= nonpos;
      s2_flags_q  <= ntc_pkg::flags_t'(inv_tag);
    end
  end

  logic                     tc_vld;
  logic [ntc_pkg::SumW-1:0] tc_quo;
  logic [FlW:0]             tc_tag;

  ntc_div_pipe #(
    .NumW (ntc_pkg::SumW),
    .DenW (ntc_pkg::SumW),
    .TagW (FlW + 1)
  ) u_tcenti_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .num_i   (s2_dvd_q),
    .den_i   (s2_dvs_q),
    .tag_i   ({s2_flags_q, s2_nonpos_q}),
    .valid_o (tc_vld),
    .quo_o   (tc_quo),
    .tag_o   (tc_tag)
  );

  ntc_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (tc_vld),
    .tcenti_i     (tc_quo),
    .flags_i      (ntc_pkg::flags_t'(tc_tag[FlW:1])),
    .nonpos_i     (tc_tag[0]),
    .off_first_i  (off_first_q),
    .off_others_i (off_others_q),
    .valid_o      (out_valid_o),
    .data_o       (out_data_o)
  );

  a_rail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ntc_pkg::StatusRail)
    |-> (out_data_o.temperature_c == '0))
    else $error("rail result with non-zero temperature");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.status == ntc_pkg::StatusOk) ||
                     (out_data_o.status == ntc_pkg::StatusRail) ||
                     (out_data_o.status == ntc_pkg::StatusClamp)))
    else $error("undefined status code");

  a_ok_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ntc_pkg::StatusOk)
    |-> ({1'b0, out_data_o.echo_channel} < 3'(ntc_pkg::NumChannels)))
    else $error("valid result on absent channel");

endmodule

FILE: rtl/ntc_div_pipe.sv
// ----------------------------------------------------------------------------
// ntc_div_pipe
// Restoring divider, one quotient bit per register stage, with side tag.
// ----------------------------------------------------------------------------
module ntc_div_pipe #(
  parameter int unsigned NumW = 36,
  parameter int unsigned DenW = 12,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);

  logic [NumW-1:0] acc_q [NumW];
  logic [DenW-1:0] rem_q [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [TagW-1:0] tag_q [NumW];
  logic [NumW-1:0] vld_q;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic            vld_in;
    logic [NumW-1:0] acc_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [TagW-1:0] tag_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            take;

    if (k == 0) begin : g_head
      assign vld_in = valid_i;
      assign acc_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_body
      assign vld_in = vld_q[k-1];
      assign acc_in = acc_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, acc_in[NumW-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[DenW-1:0] : trial[DenW-1:0];
        acc_q[k] <= {acc_in[NumW-2:0], take};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = acc_q[NumW-1];
  assign tag_o   = tag_q[NumW-1];

endmodule

FILE: rtl/ntc_ln_pipe.sv
// ----------------------------------------------------------------------------
// ntc_ln_pipe
// Natural log of a Q7.24 ratio: normalise, square per fraction bit, scale.
// ----------------------------------------------------------------------------
module ntc_ln_pipe #(
  parameter int unsigned TagW = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [ntc_pkg::RatioW-1:0]      x_i,
  input  logic [TagW-1:0]                 tag_i,
  output logic                            valid_o,
  output logic [ntc_pkg::LnMagW-1:0]      mag_o,
  output logic                            neg_o,
  output logic [TagW-1:0]                 tag_o
);

  localparam int unsigned NormN = 5;
  localparam int unsigned SqN   = ntc_pkg::FracW;
  localparam int unsigned XW    = ntc_pkg::RatioW;
  localparam int unsigned MW    = ntc_pkg::FracW + 1;

  logic [XW-1:0]   ny_q   [NormN];
  logic [4:0]      nsh_q  [NormN];
  logic [TagW-1:0] ntag_q [NormN];
  logic [NormN-1:0] nvld_q;

  for (genvar j = 0; j < NormN; j++) begin : g_norm
    localparam int unsigned Amt = 16 >> j;
    logic            vld_in;
    logic [XW-1:0]   y_in;
    logic [4:0]      sh_in;
    logic [TagW-1:0] tag_in;
    logic            zero;

    if (j == 0) begin : g_head
      assign vld_in = valid_i;
      assign y_in   = x_i;
      assign sh_in  = '0;
      assign tag_in = tag_i;
    end else begin : g_body
      assign vld_in = nvld_q[j-1];
      assign y_in   = ny_q[j-1];
      assign sh_in  = nsh_q[j-1];
      assign tag_in = ntag_q[j-1];
    end

    assign zero = (y_in[XW-1 -: Amt] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nvld_q[j] <= 1'b0;
      end else if (en_i) begin
        nvld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ny_q[j]   <= zero ? (y_in << Amt) : y_in;
        nsh_q[j]  <= zero ? (sh_in + 5'(Amt)) : sh_in;
        ntag_q[j] <= tag_in;
      end
    end
  end

  logic [MW-1:0]   m_q    [SqN];
  logic [SqN-1:0]  fr_q   [SqN];
  logic [4:0]      ssh_q  [SqN];
  logic [TagW-1:0] stag_q [SqN];
  logic [SqN-1:0]  svld_q;

  for (genvar k = 0; k < SqN; k++) begin : g_sq
    logic            vld_in;
    logic [MW-1:0]   m_in;
    logic [SqN-1:0]  fr_in;
    logic [4:0]      sh_in;
    logic [TagW-1:0] tag_in;
    logic [2*MW-1:0] prod;
    logic [MW:0]     top;

    if (k == 0) begin : g_head
      assign vld_in = nvld_q[NormN-1];
      assign m_in   = ny_q[NormN-1][XW-1 -: MW];
      assign fr_in  = '0;
      assign sh_in  = nsh_q[NormN-1];
      assign tag_in = ntag_q[NormN-1];
    end else begin : g_body
      assign vld_in = svld_q[k-1];
      assign m_in   = m_q[k-1];
      assign fr_in  = fr_q[k-1];
      assign sh_in  = ssh_q[k-1];
      assign tag_in = stag_q[k-1];
    end

    assign prod = (2*MW)'(m_in) * (2*MW)'(m_in);
    assign top  = prod[2*MW-1 -: MW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[k] <= 1'b0;
      end else if (en_i) begin
        svld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]    <= top[MW] ? top[MW:1] : top[MW-1:0];
        fr_q[k]   <= {fr_in[SqN-2:0], top[MW]};
        ssh_q[k]  <= sh_in;
        stag_q[k] <= tag_in;
      end
    end
  end

  logic [4:0]                 sh_last;
  logic [SqN-1:0]             fr_last;
  logic                       neg_a;
  logic [4:0]                 ipart;
  logic [ntc_pkg::LnMagW-1:0] l2_mag;

  assign sh_last = ssh_q[SqN-1];
  assign fr_last = fr_q[SqN-1];
  assign neg_a   = sh_last > 5'd6;
  assign ipart   = neg_a ? (sh_last - 5'd6) : (5'd6 - sh_last);
  assign l2_mag  = neg_a ? ({ipart, {SqN{1'b0}}} - ntc_pkg::LnMagW'(fr_last))
                         : ({ipart, {SqN{1'b0}}} + ntc_pkg::LnMagW'(fr_last));

  logic                       a_vld_q, b_vld_q, c_vld_q;
  logic [ntc_pkg::LnMagW-1:0] a_mag_q;
  logic                       a_neg_q, b_neg_q, c_neg_q;
  logic [TagW-1:0]            a_tag_q, b_tag_q, c_tag_q;
  logic [60:0]                b_prod_q;
  logic [ntc_pkg::LnMagW-1:0] c_mag_q;
  logic [60:0]                rnd;

  assign rnd = b_prod_q + (61'd1 << 31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= svld_q[SqN-1];
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q  <= l2_mag;
      a_neg_q  <= neg_a;
      a_tag_q  <= stag_q[SqN-1];
      b_prod_q <= 61'(a_mag_q) * 61'(ntc_pkg::Ln2Q32);
      b_neg_q  <= a_neg_q;
      b_tag_q  <= a_tag_q;
      c_mag_q  <= rnd[32 +: ntc_pkg::LnMagW];
      c_neg_q  <= b_neg_q;
      c_tag_q  <= b_tag_q;
    end
  end

  assign valid_o = c_vld_q;
  assign mag_o   = c_mag_q;
  assign neg_o   = c_neg_q;
  assign tag_o   = c_tag_q;

endmodule

FILE: rtl/ntc_finish.sv
// ----------------------------------------------------------------------------
// ntc_finish
// Kelvin to Celsius, divide by one hundred, clamp and form the result.
// ----------------------------------------------------------------------------
module ntc_finish (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [ntc_pkg::SumW-1:0]  tcenti_i,
  input  ntc_pkg::flags_t           flags_i,
  input  logic                      nonpos_i,
  input  logic [14:0]               off_first_i,
  input  logic [14:0]               off_others_i,
  output logic                      valid_o,
  output ntc_pkg::out_t             data_o
);

  logic signed [37:0] d;
  logic [14:0]        off;
  logic               hi, lo;
  logic [16:0]        absd;

  assign off  = flags_i.first ? off_first_i : off_others_i;
  assign d    = $signed({2'b00, tcenti_i}) - $signed({23'd0, off});
  assign hi   = d >= 38'(ntc_pkg::TempHiCenti);
  assign lo   = d <= 38'(ntc_pkg::TempLoCenti);
  assign absd = d[37] ? 17'(-d) : 17'(d);

  logic            f0_vld_q, f1_vld_q, f2_vld_q;
  ntc_pkg::flags_t f0_flags_q, f1_flags_q;
  logic            f0_nonpos_q, f1_nonpos_q;
  logic            f0_hi_q, f1_hi_q, f0_lo_q, f1_lo_q, f0_neg_q, f1_neg_q;
  logic [16:0]     f0_abs_q;
  logic [34:0]     f1_prod_q;
  ntc_pkg::out_t   f2_data_q;
  ntc_pkg::out_t   res;
  logic [10:0]     quo;

  assign quo = f1_prod_q[34:24];

  always_comb begin
    res.echo_channel = f1_flags_q.ch;
    res.status       = f1_flags_q.clamp ? ntc_pkg::StatusClamp : ntc_pkg::StatusOk;
    res.temperature_c = f1_neg_q ? -$signed(quo) : $signed(quo);
    if (f1_flags_q.err) begin
      res.temperature_c = '0;
      res.status        = ntc_pkg::StatusRail;
    end else if (f1_nonpos_q || f1_hi_q) begin
      res.temperature_c = ntc_pkg::TempMax;
      res.status        = ntc_pkg::StatusClamp;
    end else if (f1_lo_q) begin
      res.temperature_c = ntc_pkg::TempMin;
      res.status        = ntc_pkg::StatusClamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en_i) begin
      f0_vld_q <= valid_i;
      f1_vld_q <= f0_vld_q;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f0_flags_q  <= flags_i;
      f0_nonpos_q <= nonpos_i;
      f0_hi_q     <= hi;
      f0_lo_q     <= lo;
      f0_neg_q    <= d[37];
      f0_abs_q    <= absd;
      f1_flags_q  <= f0_flags_q;
      f1_nonpos_q <= f0_nonpos_q;
      f1_hi_q     <= f0_hi_q;
      f1_lo_q     <= f0_lo_q;
      f1_neg_q    <= f0_neg_q;
      f1_prod_q   <= 35'(f0_abs_q) * 35'(ntc_pkg::Recip100);
      f2_data_q   <= res;
    end
  end

  assign valid_o = f2_vld_q;
  assign data_o  = f2_data_q;

endmodule

FILE: tb/sv/tb_ntc_beta_temperature_converter.sv
// ----------------------------------------------------------------------------
// tb_ntc_beta_temperature_converter
// Drives ADC requests through the thermistor converter under several register
// settings and idle/stall mixes, predicts each temperature result in fixed
// point and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_ntc_beta_temperature_converter;

  localparam longint unsigned FullScale = 4095;
  localparam int ItemsPerPhase = 80;
  localparam int DrainCycles   = 200;
  localparam int HoldCycles    = 600;
  localparam int Limit         = 400000;

  typedef struct packed {
    ntc_pkg::in_t  req;
    logic          typed;
    ntc_pkg::out_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ntc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ntc_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ntc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [ntc_pkg::CfgDataW-1:0] cfg_data_i = '0;

  logic [13:0] beta_first_q, beta_others_q;
  logic [15:0] ref_temp_q;
  logic [14:0] off_first_q, off_others_q;

  ntc_pkg::out_t temps_due[$];
  int err_cnt = 0;
  int cycles = 0;
  int sent_cnt = 0;
  int seen_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_q = 1'b0;

  row_t dir_rows [0:18] = '{
    '{'{2'd0, 12'd0},    1'b1, '{11'sd0, 2'd0, ntc_pkg::StatusRail}},
    '{'{2'd0, 12'd4095}, 1'b1, '{11'sd0, 2'd0, ntc_pkg::StatusRail}},
    '{'{2'd1, 12'd0},    1'b1, '{11'sd0, 2'd1, ntc_pkg::StatusRail}},
    '{'{2'd2, 12'd4095}, 1'b1, '{11'sd0, 2'd2, ntc_pkg::StatusRail}},
    '{'{2'd3, 12'd0},    1'b1, '{11'sd0, 2'd3, ntc_pkg::StatusRail}},
    '{'{2'd3, 12'd4095}, 1'b1, '{11'sd0, 2'd3, ntc_pkg::StatusRail}},
    '{'{2'd0, 12'd1},    1'b0, '0},
    '{'{2'd0, 12'd4094}, 1'b0, '0},
    '{'{2'd1, 12'd1},    1'b0, '0},
    '{'{2'd1, 12'd4094}, 1'b0, '0},
    '{'{2'd2, 12'd4094}, 1'b0, '0},
    '{'{2'd3, 12'd1},    1'b0, '0},
    '{'{2'd0, 12'd2048}, 1'b0, '0},
    '{'{2'd1, 12'd2048}, 1'b0, '0},
    '{'{2'd2, 12'd2047}, 1'b0, '0},
    '{'{2'd3, 12'hAAA},  1'b0, '0},
    '{'{2'd0, 12'h555},  1'b0, '0},
    '{'{2'd1, 12'hFFE},  1'b0, '0},
    '{'{2'd2, 12'd1024}, 1'b0, '0}
  };

  ntc_beta_temperature_converter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic ntc_pkg::out_t convert_sample(ntc_pkg::in_t r);
    longint unsigned num, den, ratio, beta, off, t0, inv0, mag, q, tc, m, fr;
    longint l2, ln, term, s, d, tmp;
    int msb;
    logic [1:0] st;
    ntc_pkg::out_t o;
    o.echo_channel = r.channel;
    st = ntc_pkg::StatusOk;
    if (r.channel >= ntc_pkg::NumChannels || r.adc_code == 0 || r.adc_code >= FullScale) begin
      o.temperature_c = '0;
      o.status = ntc_pkg::StatusRail;
      return o;
    end
    if (r.channel == 0) begin
      num = FullScale - r.adc_code;
      den = r.adc_code;
      beta = beta_first_q;
      off = off_first_q;
    end else begin
      num = r.adc_code;
      den = FullScale - r.adc_code;
      beta = beta_others_q;
      off = off_others_q;
    end
    ratio = (num << 24) / den;
    if (ratio >= 64'h8000_0000) begin
      ratio = 64'h7FFF_FFFF;
      st = ntc_pkg::StatusClamp;
    end
    if (ratio == 0) begin
      ratio = 1;
      st = ntc_pkg::StatusClamp;
    end
    msb = 0;
    for (int i = 0; i < 31; i++) if (ratio[i]) msb = i;
    m = (msb >= 24) ? (ratio >> (msb - 24)) : (ratio << (24 - msb));
    fr = 0;
    repeat (24) begin
      m = (m * m) >> 24;
      fr = fr << 1;
      if (m >= (64'd2 << 24)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    l2 = longint'(msb - 24) * 64'sd16777216 + longint'(fr);
    mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
    mag = (mag * 64'(ntc_pkg::Ln2Q32) + (64'd1 << 31)) >> 32;
    ln = (l2 < 0) ? -longint'(mag) : longint'(mag);
    if (beta == 0) beta = 1;
    mag = (ln < 0) ? longint'(-ln) : longint'(ln);
    q = (mag * 16) / beta;
    term = (ln < 0) ? -longint'(q) : longint'(q);
    t0 = (ref_temp_q == 0) ? 1 : ref_temp_q;
    inv0 = (64'(ntc_pkg::Hundred28) + t0 / 2) / t0;
    s = term + longint'(inv0);
    if (s <= 0) begin
      tmp = 1023;
      st = ntc_pkg::StatusClamp;
    end else begin
      tc = (64'(ntc_pkg::Hundred28) + longint'(s) / 2) / longint'(s);
      d = longint'(tc) - longint'(off);
      tmp = d / 100;
      if (tmp > 1023) begin
        tmp = 1023;
        st = ntc_pkg::StatusClamp;
      end
      if (tmp < -128) begin
        tmp = -128;
        st = ntc_pkg::StatusClamp;
      end
    end
    o.temperature_c = tmp[10:0];
    o.status = st;
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want, seen_cnt);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    ntc_pkg::out_t e;
    out_stall_i <= hold_q || ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_cnt++;
      if (temps_due.size() == 0) begin
        report("unrequested result", out_data_o.echo_channel, -1);
      end else begin
        e = temps_due.pop_front();
        if (out_data_o.temperature_c !== e.temperature_c)
          report("temperature_c", out_data_o.temperature_c, e.temperature_c);
        if (out_data_o.echo_channel !== e.echo_channel)
          report("echo_channel", out_data_o.echo_channel, e.echo_channel);
        if (out_data_o.status !== e.status)
          report("status", out_data_o.status, e.status);
      end
    end
  end

  task automatic send_request(ntc_pkg::in_t r, logic typed, ntc_pkg::out_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    temps_due.push_back(typed ? res : convert_sample(r));
    sent_cnt++;
  endtask

  function automatic ntc_pkg::in_t random_request();
    ntc_pkg::in_t r;
    int sel;
    r.channel = 2'($urandom_range(3));
    sel = $urandom_range(99);
    if (sel < 4) r.adc_code = 12'd0;
    else if (sel < 8) r.adc_code = 12'd4095;
    else if (sel < 16) r.adc_code = 12'($urandom_range(8, 1));
    else if (sel < 24) r.adc_code = 12'($urandom_range(4094, 4087));
    else r.adc_code = 12'($urandom_range(4094, 1));
    return r;
  endfunction

  task automatic write_reg(ntc_pkg::cfg_idx_e idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ntc_pkg::CfgBetaFirst:  beta_first_q = v[13:0];
      ntc_pkg::CfgBetaOthers: beta_others_q = v[13:0];
      ntc_pkg::CfgRefTemp:    ref_temp_q = v;
      ntc_pkg::CfgOffFirst:   off_first_q = v[14:0];
      ntc_pkg::CfgOffOthers:  off_others_q = v[14:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (temps_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  logic [15:0] setting [0:5][0:4];
  int phase_idle [0:3] = '{0, 54, 0, 20};
  int phase_stall [0:3] = '{0, 0, 54, 20};

  initial begin
    beta_first_q = ntc_pkg::BetaFirstRst;
    beta_others_q = ntc_pkg::BetaOthersRst;
    ref_temp_q = ntc_pkg::RefTempRst;
    off_first_q = ntc_pkg::OffFirstRst;
    off_others_q = ntc_pkg::OffOthersRst;
    setting[0] = '{16'd1000, 16'd1000, 16'd20000, 16'd25000, 16'd25000};
    setting[1] = '{16'd10000, 16'd10000, 16'd40000, 16'd30000, 16'd30000};
    setting[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    setting[3] = '{16'h3FFF, 16'h3FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF};
    setting[4] = '{16'(ntc_pkg::BetaFirstRst), 16'(ntc_pkg::BetaOthersRst),
                   16'(ntc_pkg::RefTempRst), 16'(ntc_pkg::OffFirstRst),
                   16'(ntc_pkg::OffOthersRst)};
    setting[5] = '{16'($urandom_range(10000, 1000)), 16'($urandom_range(10000, 1000)),
                   16'($urandom_range(40000, 20000)), 16'($urandom_range(30000, 25000)),
                   16'($urandom_range(30000, 25000))};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int k = 0; k < 6; k++) begin
      write_reg(ntc_pkg::CfgBetaFirst, setting[k][0]);
      write_reg(ntc_pkg::CfgBetaOthers, setting[k][1]);
      write_reg(ntc_pkg::CfgRefTemp, setting[k][2]);
      write_reg(ntc_pkg::CfgOffFirst, setting[k][3]);
      write_reg(ntc_pkg::CfgOffOthers, setting[k][4]);
      cfg_valid_i <= 1'b0;
      for (int p = 0; p < 4; p++) begin
        idle_pct = phase_idle[p];
        stall_pct = phase_stall[p];
        if (k == 0 && p == 0) begin
          fork
            begin
              hold_q <= 1'b1;
              repeat (HoldCycles) @(posedge clk_i);
              hold_q <= 1'b0;
            end
          join_none
        end
        repeat (ItemsPerPhase) send_request(random_request(), 1'b0, '0);
      end
      idle_pct = 0;
      stall_pct = 0;
      drain();
    end

    $display("%0d requests sent, %0d results checked over 7 register settings", sent_cnt,
             seen_cnt);
    $display("phases covered free flow, sender gaps, receiver stalls and a long hold-off");
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: ntc_beta_temperature_converter.f
rtl/ntc_pkg.sv
rtl/ntc_div_pipe.sv
rtl/ntc_ln_pipe.sv
rtl/ntc_finish.sv
rtl/ntc_beta_temperature_converter.sv
tb/sv/tb_ntc_beta_temperature_converter.sv
